/* rtl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants, operation codes, state codes and the command and status
// structs that join the slot cache controller and datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int SLOT_COUNT  = 16;

  localparam int OP_W    = 4;
  localparam int ID_W    = 10;
  localparam int SLOT_W  = 4;
  localparam int RC_W    = 11;
  localparam int MS_W    = $clog2(SLOT_COUNT);
  localparam int ENTRY_W = MS_W + 1;
  localparam int CNT_W   = $clog2(MAX_RECORDS) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP      = 4'd0,
    OP_BIND_LOAD   = 4'd1,
    OP_BIND_RSV    = 4'd2,
    OP_CLAIM       = 4'd3,
    OP_LOCK        = 4'd4,
    OP_UNLOCK      = 4'd5,
    OP_RELEASE     = 4'd6,
    OP_RELEASE_ALL = 4'd7,
    OP_CLEAR       = 4'd8,
    OP_FLUSH_QUERY = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep_init;
    logic sweep_step;
    logic clear_step;
    logic finish;
  } psc_cmd_t;

  typedef struct packed {
    logic go_sweep;
    logic go_clear;
    logic sweep_done;
    logic clear_last;
  } psc_status_t;

endpackage

/* rtl/psc_ram.sv */
// ----------------------------------------------------------------------------
// psc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module psc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/psc_ctrl.sv */
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer for the slot cache: clearing pass after reset, command accept,
// execute, release sweep and clear sweep.
// ----------------------------------------------------------------------------
module psc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  psc_pkg::psc_status_t  status_i,
  output psc_pkg::psc_cmd_t     cmd_o
);
  import psc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.go_clear) begin
          cmd_o.sweep_init = 1'b1;
          state_d          = ST_CLEAR;
        end else if (status_i.go_sweep) begin
          cmd_o.sweep_init = 1'b1;
          state_d          = ST_SWEEP;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (status_i.sweep_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.sweep_step = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

/* rtl/psc_datapath.sv */
// ----------------------------------------------------------------------------
// psc_datapath
// Remap memory, free and lock masks, dirty flag, record_count register,
// sweep counter and result registers of the slot cache.
// ----------------------------------------------------------------------------
module psc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psc_pkg::psc_cmd_t           cmd_i,
  output psc_pkg::psc_status_t        status_o,
  input  logic [psc_pkg::OP_W-1:0]    operation_i,
  input  logic [psc_pkg::ID_W-1:0]    record_id_i,
  input  logic [psc_pkg::SLOT_W-1:0]  slot_i,
  input  logic                        cfg_we_i,
  input  logic [psc_pkg::RC_W-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic [psc_pkg::SLOT_W-1:0]  slot_out_o,
  output logic                        success_o,
  output logic                        load_record_o,
  output logic                        upload_all_o
);
  import psc_pkg::*;

  logic [OP_W-1:0]       op_q;
  logic [ID_W-1:0]       id_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [RC_W-1:0]       rc_q;
  logic [SLOT_COUNT-1:0] free_q, free_d;
  logic [SLOT_COUNT-1:0] lock_q, lock_d;
  logic                  dirty_q, dirty_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  iss_q, iss_d;
  logic [ID_W-1:0]       wb_addr_q;
  logic                  done_q, done_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic                  success_q, success_d;
  logic                  load_q, load_d;
  logic                  upload_q, upload_d;

  logic                  ram_we;
  logic [ID_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ID_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic [CNT_W-1:0]      lim;
  logic                  id_ok;
  logic                  slot_ok;
  logic [MS_W-1:0]       slot_idx;
  logic                  rd_valid;
  logic [MS_W-1:0]       rd_slot;
  logic                  free_any;
  logic [MS_W-1:0]       free_idx;
  logic                  sweep_hit;
  logic                  sweep_issue;

  psc_ram #(
    .Width (ENTRY_W),
    .Depth (MAX_RECORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (32'(rc_q) > MAX_RECORDS) begin
      lim = CNT_W'(MAX_RECORDS);
    end else begin
      lim = CNT_W'(rc_q);
    end
  end

  assign id_ok       = CNT_W'(id_q) < lim;
  assign slot_ok     = 32'(slot_q) < SLOT_COUNT;
  assign slot_idx    = MS_W'(slot_q);
  assign rd_valid    = ram_rdata[ENTRY_W-1];
  assign rd_slot     = ram_rdata[MS_W-1:0];
  assign free_any    = |free_q;
  assign sweep_issue = cnt_q < lim;
  assign sweep_hit   = (op_q == OP_RELEASE) ? (rd_slot == slot_idx) : !lock_q[rd_slot];

  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_idx = MS_W'(i);
      end
    end
  end

  always_comb begin
    status_o.go_sweep   = (op_q == OP_RELEASE && slot_ok && !lock_q[slot_idx]) ||
                          (op_q == OP_RELEASE_ALL);
    status_o.go_clear   = op_q == OP_CLEAR;
    status_o.sweep_done = !sweep_issue && !iss_q;
    status_o.clear_last = cnt_q == CNT_W'(MAX_RECORDS - 1);
  end

  always_comb begin
    free_d     = free_q;
    lock_d     = lock_q;
    dirty_d    = dirty_q;
    cnt_d      = cnt_q;
    iss_d      = iss_q;
    ram_we     = 1'b0;
    ram_waddr  = id_q;
    ram_wdata  = '0;
    ram_raddr  = record_id_i;
    done_d     = 1'b0;
    res_slot_d = '0;
    success_d  = 1'b0;
    load_d     = 1'b0;
    upload_d   = 1'b0;

    if (cmd_i.exec) begin
      done_d = 1'b1;
      case (op_e'(op_q))
        OP_LOOKUP: begin
          if (id_ok) begin
            if (rd_valid) begin
              res_slot_d = SLOT_W'(rd_slot);
              success_d  = 1'b1;
            end else begin
              dirty_d = 1'b1;
              if (free_any) begin
                free_d[free_idx] = 1'b0;
                ram_we           = 1'b1;
                ram_wdata        = {1'b1, free_idx};
                res_slot_d       = SLOT_W'(free_idx);
                success_d        = 1'b1;
                load_d           = 1'b1;
              end
            end
          end
        end
        OP_BIND_LOAD, OP_BIND_RSV: begin
          if (id_ok && slot_ok) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, slot_idx};
            success_d = 1'b1;
            if (op_q == OP_BIND_LOAD) begin
              dirty_d    = 1'b1;
              res_slot_d = slot_q;
              load_d     = 1'b1;
            end else begin
              free_d[slot_idx] = 1'b0;
            end
          end
        end
        OP_CLAIM: begin
          if (slot_ok && free_q[slot_idx]) begin
            free_d[slot_idx] = 1'b0;
            success_d        = 1'b1;
          end
        end
        OP_LOCK, OP_UNLOCK: begin
          if (id_ok && rd_valid) begin
            lock_d[rd_slot] = op_q == OP_LOCK;
            success_d       = 1'b1;
          end
        end
        OP_FLUSH_QUERY: begin
          upload_d = dirty_q;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.sweep_init) begin
      cnt_d = '0;
      iss_d = 1'b0;
      case (op_e'(op_q))
        OP_RELEASE: begin
          free_d[slot_idx] = 1'b1;
        end
        OP_RELEASE_ALL: begin
          free_d = free_q | ~lock_q;
        end
        OP_CLEAR: begin
          free_d = '1;
          lock_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.sweep_step) begin
      ram_raddr = cnt_q[ID_W-1:0];
      iss_d     = sweep_issue;
      if (sweep_issue) begin
        cnt_d = cnt_q + 1'b1;
      end
      ram_we    = iss_q;
      ram_waddr = wb_addr_q;
      ram_wdata = {rd_valid & !sweep_hit, rd_slot};
    end

    if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[ID_W-1:0];
      ram_wdata = '0;
      cnt_d     = cnt_q + 1'b1;
    end

    if (cmd_i.finish) begin
      done_d    = 1'b1;
      success_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q    <= '0;
      free_q  <= '1;
      lock_q  <= '0;
      dirty_q <= 1'b0;
      cnt_q   <= '0;
      iss_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rc_q <= cfg_wdata_i;
      end
      free_q  <= free_d;
      lock_q  <= lock_d;
      dirty_q <= dirty_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      id_q   <= record_id_i;
      slot_q <= slot_i;
    end
    if (cmd_i.sweep_step) begin
      wb_addr_q <= cnt_q[ID_W-1:0];
    end
    res_slot_q <= res_slot_d;
    success_q  <= success_d;
    load_q     <= load_d;
    upload_q   <= upload_d;
  end

  assign done_o        = done_q;
  assign slot_out_o    = res_slot_q;
  assign success_o     = success_q;
  assign load_record_o = load_q;
  assign upload_all_o  = upload_q;

  a_no_write_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !ram_we)
    else $error("map write in accept cycle");

  a_load_needs_success : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && load_q |-> success_q)
    else $error("load request without success");

  a_clear_resets_masks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_init && op_q == OP_CLEAR |=> free_q == '1 && lock_q == '0)
    else $error("clear left masks dirty");

  a_accept_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> !done_q)
    else $error("result strobe right after accept");

endmodule

/* rtl/palette_slot_cache_allocator.sv */
// ----------------------------------------------------------------------------
// palette_slot_cache_allocator
// Maps record ids to hardware slots through a remap memory, with free and
// lock masks and a dirty flag.
//
// Usage: drive operation_i, record_id_i and slot_i and raise start; the
// command is taken at a rising edge where start is high and busy is low.
// Each command gives one result on slot_out_o, success_o, load_record_o
// and upload_all_o, valid for the single cycle in which done_o is high.
// The receiver cannot stall: the result is gone after that cycle.
// Lookup, bind, claim, lock, unlock and flush query pass from accept through
// the execute state to a registered result; the remap memory is read at
// accept, written where needed in execute, before a new command is taken.
// Release and release unlocked sweep ids below lim = min(record_count, 1024),
// one entry per cycle; a release of a locked slot is refused with no sweep.
// Clear sweeps all 1024 entries.
// The user must write record_count (cfg_we_i / cfg_wdata_i) only while idle;
// the block does not enforce it. After reset busy stays high for a clearing
// pass of the remap memory; configuration writes are taken during it.
// ----------------------------------------------------------------------------
module palette_slot_cache_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [psc_pkg::OP_W-1:0]    operation_i,
  input  logic [psc_pkg::ID_W-1:0]    record_id_i,
  input  logic [psc_pkg::SLOT_W-1:0]  slot_i,
  input  logic                        cfg_we_i,
  input  logic [psc_pkg::RC_W-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic [psc_pkg::SLOT_W-1:0]  slot_out_o,
  output logic                        success_o,
  output logic                        load_record_o,
  output logic                        upload_all_o
);
  import psc_pkg::*;

  psc_cmd_t    cmd;
  psc_status_t status;

  psc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  psc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (operation_i),
    .record_id_i   (record_id_i),
    .slot_i        (slot_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .slot_out_o    (slot_out_o),
    .success_o     (success_o),
    .load_record_o (load_record_o),
    .upload_all_o  (upload_all_o)
  );

endmodule

/* tb/palette_slot_cache_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_slot_cache_checker
// Watches the command, configuration and result ports of the slot cache,
// keeps its own copy of the remap table, masks, dirty flag and record range,
// predicts the reply of every accepted transaction and compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module palette_slot_cache_checker
  import psc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [ID_W-1:0]   record_id_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic              cfg_we_i,
  input  logic [RC_W-1:0]   cfg_wdata_i,
  input  logic              done_o,
  input  logic [SLOT_W-1:0] slot_out_o,
  input  logic              success_o,
  input  logic              load_record_o,
  input  logic              upload_all_o,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              success;
    logic              load_record;
    logic              upload_all;
  } cache_reply_t;

  cache_reply_t      reply_q[$];
  bit                map_valid[MAX_RECORDS];
  logic [MS_W-1:0]   map_slot[MAX_RECORDS];
  logic [SLOT_COUNT-1:0] free_mask;
  logic [SLOT_COUNT-1:0] lock_mask;
  logic              dirty;
  logic [RC_W-1:0]   record_count;
  int                fails = 0;

  function automatic int unsigned id_limit();
    return (record_count < MAX_RECORDS) ? record_count : MAX_RECORDS;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < MAX_RECORDS; i++) begin
      map_valid[i] = 1'b0;
      map_slot[i]  = '0;
    end
    free_mask = '1;
    lock_mask = '0;
  endfunction

  // Free the slot and unmap every id in range that points at it.
  function automatic void release_slot(int unsigned s);
    int unsigned lim;
    lim = id_limit();
    free_mask[s] = 1'b1;
    for (int unsigned i = 0; i < lim; i++) begin
      if (map_valid[i] && map_slot[i] == s) map_valid[i] = 1'b0;
    end
  endfunction

  function automatic cache_reply_t predict_reply(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                 logic [SLOT_W-1:0] s);
    cache_reply_t r;
    logic         id_ok;
    logic         slot_ok;
    int           idx;
    r       = '0;
    id_ok   = int'(id) < id_limit();
    slot_ok = int'(s) < SLOT_COUNT;
    case (op)
      OP_LOOKUP: begin
        if (id_ok) begin
          if (map_valid[id]) begin
            r.slot    = map_slot[id];
            r.success = 1'b1;
          end else begin
            dirty = 1'b1;
            idx   = -1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (idx < 0 && free_mask[i]) idx = i;
            end
            if (idx >= 0) begin
              free_mask[idx] = 1'b0;
              map_valid[id]  = 1'b1;
              map_slot[id]   = idx[MS_W-1:0];
              r.slot         = idx[SLOT_W-1:0];
              r.success      = 1'b1;
              r.load_record  = 1'b1;
            end
          end
        end
      end
      OP_BIND_LOAD, OP_BIND_RSV: begin
        if (id_ok && slot_ok) begin
          map_valid[id] = 1'b1;
          map_slot[id]  = s[MS_W-1:0];
          r.success     = 1'b1;
          if (op == OP_BIND_LOAD) begin
            dirty         = 1'b1;
            r.slot        = s;
            r.load_record = 1'b1;
          end else begin
            free_mask[s] = 1'b0;
          end
        end
      end
      OP_CLAIM: begin
        if (slot_ok && free_mask[s]) begin
          free_mask[s] = 1'b0;
          r.success    = 1'b1;
        end
      end
      OP_LOCK, OP_UNLOCK: begin
        if (id_ok && map_valid[id]) begin
          lock_mask[map_slot[id]] = (op == OP_LOCK);
          r.success = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (slot_ok && !lock_mask[s]) begin
          release_slot(s);
          r.success = 1'b1;
        end
      end
      OP_RELEASE_ALL: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!lock_mask[i]) release_slot(i);
        end
        r.success = 1'b1;
      end
      OP_CLEAR: begin
        clear_tables();
        r.success = 1'b1;
      end
      OP_FLUSH_QUERY: r.upload_all = dirty;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [SLOT_W-1:0] expv,
                                      logic [SLOT_W-1:0] actv);
    if (actv !== expv) begin
      fails++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $realtime, name, expv, actv);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t exp_r;
    if (!rst_ni) begin
      clear_tables();
      dirty        = 1'b0;
      record_count = '0;
      reply_q.delete();
    end else begin
      if (done_o) begin
        if (reply_q.size() == 0) begin
          fails++;
          $display("%0t: result with no transaction pending: slot %0h success %0b load %0b upload %0b",
                   $realtime, slot_out_o, success_o, load_record_o, upload_all_o);
        end else begin
          exp_r = reply_q.pop_front();
          check_field("slot_out", exp_r.slot, slot_out_o);
          check_field("success", SLOT_W'(exp_r.success), SLOT_W'(success_o));
          check_field("load_record", SLOT_W'(exp_r.load_record), SLOT_W'(load_record_o));
          check_field("upload_all", SLOT_W'(exp_r.upload_all), SLOT_W'(upload_all_o));
        end
      end
      if (cfg_we_i) record_count = cfg_wdata_i;
      if (start && !busy) reply_q.push_back(predict_reply(operation_i, record_id_i, slot_i));
    end
    pending_o    = reply_q.size();
    fail_count_o = fails;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for palette_slot_cache_allocator: a directed pass over
// every operation and corner of the record range, then random transactions
// over a series of record_count settings with varying sender idle rates.
// Checking is done by palette_slot_cache_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  import psc_pkg::*;

  localparam int              CLK_PERIOD     = 10;
  localparam int              STALL_LIMIT    = 4000;
  localparam int              PHASE_ITEMS    = 110;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd10;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   operation_i = '0;
  logic [ID_W-1:0]   record_id_i = '0;
  logic [SLOT_W-1:0] slot_i      = '0;
  logic              cfg_we_i    = 1'b0;
  logic [RC_W-1:0]   cfg_wdata_i = '0;
  logic              done_o;
  logic [SLOT_W-1:0] slot_out_o;
  logic              success_o;
  logic              load_record_o;
  logic              upload_all_o;
  int                fail_count;
  int                pending;
  int unsigned       idle_pct    = 33;
  int unsigned       range_now   = 0;
  int                stall_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  palette_slot_cache_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .record_id_i   (record_id_i),
    .slot_i        (slot_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .slot_out_o    (slot_out_o),
    .success_o     (success_o),
    .load_record_o (load_record_o),
    .upload_all_o  (upload_all_o)
  );

  palette_slot_cache_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .record_id_i   (record_id_i),
    .slot_i        (slot_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .slot_out_o    (slot_out_o),
    .success_o     (success_o),
    .load_record_o (load_record_o),
    .upload_all_o  (upload_all_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[palette_slot_cache_allocator] ERROR");
      $finish;
    end
  end

  task automatic send_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [SLOT_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    record_id_i <= id;
    slot_i      <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain all outstanding transactions before touching record_count.
  task automatic set_record_count(input int unsigned value);
    start <= 1'b0;
    while (pending != 0 || busy !== 1'b0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= RC_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    range_now = value;
  endtask

  function automatic logic [OP_W-1:0] pick_operation();
    int unsigned r = $urandom_range(999);
    if (r < 300) return OP_LOOKUP;
    if (r < 380) return OP_BIND_LOAD;
    if (r < 450) return OP_BIND_RSV;
    if (r < 530) return OP_CLAIM;
    if (r < 610) return OP_LOCK;
    if (r < 680) return OP_UNLOCK;
    if (r < 830) return OP_RELEASE;
    if (r < 870) return OP_RELEASE_ALL;
    if (r < 885) return OP_CLEAR;
    if (r < 960) return OP_FLUSH_QUERY;
    return OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
  endfunction

  // Favor a small pool of ids so that hits, locks and slot exhaustion occur.
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r = $urandom_range(99);
    if (range_now == 0 || r < 8) return ID_W'($urandom_range(MAX_RECORDS - 1));
    if (r < 15 && range_now < MAX_RECORDS)
      return ID_W'($urandom_range(MAX_RECORDS - 1, range_now));
    if (r < 80 && range_now > 24) return ID_W'($urandom_range(23));
    return ID_W'($urandom_range(range_now - 1));
  endfunction

  initial begin
    int unsigned      range_plan[10] = '{24, 1024, 0, 17, 1, 1023, 64, 24, 300, 20};
    int unsigned      counted;
    logic [OP_W-1:0]  op;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_record_count(MAX_RECORDS);
    send_command(OP_FLUSH_QUERY, 10'd0, 4'd0);
    send_command(OP_LOOKUP, 10'd0, 4'd0);
    send_command(OP_LOOKUP, 10'd0, 4'd0);
    send_command(OP_LOOKUP, 10'd1023, 4'd15);
    send_command(OP_BIND_LOAD, 10'd5, 4'd15);
    send_command(OP_BIND_RSV, 10'd6, 4'd14);
    send_command(OP_CLAIM, 10'd0, 4'd2);
    send_command(OP_CLAIM, 10'd0, 4'd2);
    send_command(OP_LOCK, 10'd0, 4'd0);
    send_command(OP_RELEASE, 10'd0, 4'd0);
    send_command(OP_UNLOCK, 10'd0, 4'd0);
    send_command(OP_LOCK, 10'd999, 4'd0);
    send_command(OP_RELEASE, 10'd0, 4'd0);
    send_command(OP_RELEASE_ALL, 10'd0, 4'd0);
    send_command(OP_SPARE_LAST, 10'd1023, 4'd15);
    send_command(OP_FLUSH_QUERY, 10'd0, 4'd0);
    send_command(OP_CLEAR, 10'd0, 4'd0);
    send_command(OP_FLUSH_QUERY, 10'd0, 4'd0);
    send_command(OP_BIND_RSV, 10'd900, 4'd3);

    // Shrink the range: id 900 keeps its mapping through a release of its slot.
    set_record_count(8);
    send_command(OP_LOOKUP, 10'd8, 4'd0);
    send_command(OP_RELEASE, 10'd0, 4'd3);
    set_record_count(0);
    send_command(OP_LOOKUP, 10'd0, 4'd0);
    set_record_count(MAX_RECORDS);
    send_command(OP_LOOKUP, 10'd900, 4'd0);

    foreach (range_plan[p]) begin
      idle_pct = (p < 3) ? 33 : (p < 7) ? 56 : 0;
      set_record_count(range_plan[p]);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        op = pick_operation();
        send_command(op, pick_id(), SLOT_W'($urandom_range(SLOT_COUNT - 1)));
        if (op <= OP_FLUSH_QUERY) counted++;
      end
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[palette_slot_cache_allocator] OK");
    end else begin
      $display("[palette_slot_cache_allocator] ERROR");
    end
    $finish;
  end

endmodule
